FILE: hw/rtl/ffra_pkg.sv
package ffra_pkg;

	localparam int REGION_ENTRIES = 64;
	localparam int BLOCK_BYTES    = 4096;
	localparam int IDX_W          = $clog2(REGION_ENTRIES);
	localparam int CNT_W          = $clog2(REGION_ENTRIES + 1);
	localparam int AW             = 48;
	localparam int BLK_W          = 20;

	localparam logic [AW-1:0]    KERNEL_BASE = AW'(64'h10_0000);
	localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(REGION_ENTRIES);
	localparam logic [CNT_W-1:0] MOVED_MAX   = CNT_W'(REGION_ENTRIES - 1);

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_ALLOC = 2'd2,
		REQ_FREE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_IGN   = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} fsm_t;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		req_t             op;
		logic             start;
		logic             scan;
		logic             clear_tok;
		logic             pop_en;
		logic [IDX_W-1:0] pop_slot;
		logic             shift_en;
		logic [CNT_W-1:0] moved;
		logic [AW-1:0]    rbase;
		logic [AW-1:0]    rsize;
		logic [AW-1:0]    need;
	} ctl_t;

	function automatic logic [AW-1:0] blocks_to_bytes(input logic [BLK_W-1:0] blocks);
		logic [AW-1:0] prod;
		prod = AW'(blocks) * AW'(BLOCK_BYTES);
		return prod;
	endfunction

endpackage

FILE: hw/rtl/ffra_cell.sv
module ffra_cell
	import ffra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] my_idx,
	input  ctl_t             ctl,
	input  logic             tok_in,
	input  logic [AW-1:0]    sh_base_in,
	input  logic [AW-1:0]    sh_size_in,
	output logic             tok_out,
	output logic             hit,
	output logic [AW-1:0]    hit_base,
	output logic [AW-1:0]    base_out,
	output logic [AW-1:0]    size_out
);

	logic          tok_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] size_q;
	logic          empty;
	logic          fits;
	logic          cond;

	// Match condition for the request under the token
	assign empty    = (base_q == '0) && (size_q == '0);
	assign fits     = (base_q != '0) && (size_q != '0) && (size_q >= ctl.need);
	assign cond     = (ctl.op == REQ_PUSH) ? empty : fits;
	assign hit      = tok_q & ctl.scan & cond;
	assign tok_out  = tok_q & ~cond;
	assign hit_base = hit ? base_q : '0;
	assign base_out = base_q;
	assign size_out = size_q;

	// Advance the search token one cell per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clear_tok) begin
			tok_q <= 1'b0;
		end else if (ctl.start || ctl.scan) begin
			tok_q <= tok_in;
		end
	end

	// Update the region entry: fill, carve, clear or shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= '0;
		end else if (hit) begin
			if (ctl.op == REQ_PUSH) begin
				base_q <= ctl.rbase;
				size_q <= ctl.rsize;
			end else begin
				base_q <= base_q + ctl.need;
				size_q <= size_q - ctl.need;
			end
		end else if (ctl.pop_en && (my_idx == ctl.pop_slot)) begin
			base_q <= '0;
			size_q <= '0;
		end else if (ctl.shift_en && ({1'b0, my_idx} <= CNT_W'(ctl.moved))) begin
			base_q <= sh_base_in;
			size_q <= sh_size_in;
		end
	end

endmodule

FILE: hw/rtl/ffra_chain.sv
module ffra_chain
	import ffra_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_t          ctl,
	input  logic [AW-1:0] free_base,
	output logic          hit_any,
	output logic [AW-1:0] hit_base
);

	logic [REGION_ENTRIES-1:0]         tok_v;
	logic [REGION_ENTRIES-1:0]         hit_v;
	logic [REGION_ENTRIES-1:0][AW-1:0] hb_v;
	logic [REGION_ENTRIES-1:0][AW-1:0] base_v;
	logic [REGION_ENTRIES-1:0][AW-1:0] size_v;

	// Build the row; each cell after the first takes token and shift data from its left neighbor
	for (genvar i = 0; i < REGION_ENTRIES; i++) begin : g_cell
		logic          tin;
		logic [AW-1:0] bin;
		logic [AW-1:0] sin;
		if (i == 0) begin : g_head
			assign tin = ctl.start;
			assign bin = free_base;
			assign sin = ctl.need;
		end else begin : g_body
			assign tin = tok_v[i-1];
			assign bin = base_v[i-1];
			assign sin = size_v[i-1];
		end
		ffra_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.my_idx     (IDX_W'(i)),
			.ctl        (ctl),
			.tok_in     (tin),
			.sh_base_in (bin),
			.sh_size_in (sin),
			.tok_out    (tok_v[i]),
			.hit        (hit_v[i]),
			.hit_base   (hb_v[i]),
			.base_out   (base_v[i]),
			.size_out   (size_v[i])
		);
	end

	// Collect the single hit; at most one cell holds the token
	always_comb begin
		hit_base = '0;
		for (int i = 0; i < REGION_ENTRIES; i++) begin
			hit_base = hit_base | hb_v[i];
		end
	end
	assign hit_any = |hit_v;

endmodule

FILE: hw/rtl/first_fit_region_allocator.sv
// First-fit free region allocator.
// Input channel (in_valid/in_stall) carries one transaction: req_type plus
// region_base, region_size, block_count and free_address. Output channel
// (out_valid/out_stall) returns one transaction per request: alloc_address,
// used_memory and status. An APB port writes kernel_reserve_size at 0 to 7.
// The table sits in a row of 64 cells. Push and allocate send a token down
// the row one cell per cycle while the output register is not stalled, and
// stop at the slot that matches or at the search limit on a miss. Free
// shifts cells 0 up to the entry count (at most 63) into their neighbors at once.
// One request is worked at a time; in_stall is high while it is in flight.
// A finished result waits in the output register; the next request is
// taken meanwhile, but its later steps wait until that result is taken,
// so a stalled receiver holds the block and nothing is lost.
// Reset empties the table, zeroes count, last pushed slot, used total and
// the reserve register, and leaves the output channel empty.
module first_fit_region_allocator
	import ffra_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       req_type,
	input  logic [AW-1:0]    region_base,
	input  logic [AW-1:0]    region_size,
	input  logic [BLK_W-1:0] block_count,
	input  logic [AW-1:0]    free_address,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [AW-1:0]    alloc_address,
	output logic [AW-1:0]    used_memory,
	output logic [1:0]       status
);

	fsm_t             state_q, state_d;
	logic [AW-1:0]    kres_q;
	req_t             op_q;
	logic [AW-1:0]    rbase_q;
	logic [AW-1:0]    rsize_q;
	logic [AW-1:0]    need_q;
	logic [AW-1:0]    faddr_q;
	logic             fign_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] lim_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] last_q;
	logic [AW-1:0]    used_q;
	logic             out_valid_q;
	logic [AW-1:0]    addr_out_q;
	logic [AW-1:0]    used_out_q;
	status_t          stat_out_q;

	logic             accept;
	logic             out_free;
	logic             run;
	logic             finish;
	logic             cnt_up;
	logic             set_last;
	logic [AW-1:0]    used_d;
	logic [AW-1:0]    addr_d;
	status_t          stat_d;
	logic [AW-1:0]    adj_base;
	req_t             req_in;
	ctl_t             ctl;
	logic             hit_any;
	logic [AW-1:0]    hit_base;

	assign req_in   = req_t'(req_type);
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign run      = (state_q == S_SCAN) && out_free;
	assign adj_base = (region_base == KERNEL_BASE) ? region_base + kres_q : region_base;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = {16'b0, kres_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kres_q <= '0;
		end else if (psel && penable && pwrite && !paddr[3]) begin
			kres_q <= pwdata[AW-1:0];
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req_in;
			rbase_q <= adj_base;
			rsize_q <= region_size;
			need_q  <= blocks_to_bytes(block_count);
			faddr_q <= free_address;
			fign_q  <= (block_count == '0) || (free_address == '0);
			if (req_in == REQ_PUSH) begin
				lim_q <= (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 1'b1;
			end else begin
				lim_q <= cnt_q;
			end
		end
	end

	// Sequence the request and drive the row
	always_comb begin
		state_d       = state_q;
		finish        = 1'b0;
		cnt_up        = 1'b0;
		set_last      = 1'b0;
		used_d        = used_q;
		addr_d        = '0;
		stat_d        = ST_DONE;
		ctl           = '0;
		ctl.op        = op_q;
		ctl.rbase     = rbase_q;
		ctl.rsize     = rsize_q;
		ctl.need      = need_q;
		ctl.pop_slot  = last_q;
		ctl.moved     = (cnt_q > MOVED_MAX) ? MOVED_MAX : cnt_q;
		ctl.start     = accept && ((req_in == REQ_PUSH) || (req_in == REQ_ALLOC));
		if (run) begin
			unique case (op_q)
				REQ_PUSH, REQ_ALLOC: begin
					if (idx_q >= lim_q) begin
						finish        = 1'b1;
						ctl.clear_tok = 1'b1;
						stat_d        = (op_q == REQ_PUSH) ? ST_FULL : ST_NOFIT;
						cnt_up        = (op_q == REQ_PUSH);
					end else begin
						ctl.scan = 1'b1;
						if (hit_any) begin
							finish = 1'b1;
							if (op_q == REQ_PUSH) begin
								cnt_up   = 1'b1;
								set_last = 1'b1;
							end else begin
								addr_d = hit_base;
								used_d = used_q + need_q;
							end
						end
					end
				end
				REQ_POP: begin
					finish = 1'b1;
					if (last_q == '0) begin
						stat_d = ST_IGN;
					end else begin
						ctl.pop_en = 1'b1;
					end
				end
				REQ_FREE: begin
					finish = 1'b1;
					if (fign_q) begin
						stat_d = ST_IGN;
					end else begin
						ctl.shift_en = 1'b1;
						cnt_up       = 1'b1;
						used_d       = used_q - need_q;
						stat_d       = (cnt_q >= CNT_MAX) ? ST_FULL : ST_DONE;
					end
				end
				default: ;
			endcase
		end
		unique case (state_q)
			S_IDLE:  if (accept) state_d = S_SCAN;
			S_SCAN:  if (finish) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	ffra_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.free_base (faddr_q),
		.hit_any   (hit_any),
		.hit_base  (hit_base)
	);

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= '0;
			last_q  <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (accept) begin
				idx_q <= '0;
			end else if (ctl.scan && !hit_any) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cnt_up && (cnt_q != CNT_MAX)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (set_last) begin
				last_q <= idx_q[IDX_W-1:0];
			end
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			addr_out_q <= addr_d;
			used_out_q <= used_d;
			stat_out_q <= stat_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign alloc_address = addr_out_q;
	assign used_memory   = used_out_q;
	assign status        = stat_out_q;

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above capacity");

	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q >= $past(cnt_q))
		else $error("entry count went down");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SCAN)
		else $error("accepted request not in flight");

	a_idle_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !hit_any)
		else $error("cell hit while idle");

endmodule
